// ===== rtl/core/reciprocal_frequency_meter_unit_assert.svh =====
// Assertion macros for the reciprocal frequency meter.
// Included by the top level; needs no other file.
`ifndef RECIPROCAL_FREQUENCY_METER_UNIT_ASSERT_SVH
`define RECIPROCAL_FREQUENCY_METER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define RFM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfm assertion failed");
// Next-cycle implication.
`define RFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfm assertion failed");
`else
`define RFM_ASSERT_NOW(label, clk, rst, ante, cons)
`define RFM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/rfm_pkg.sv =====
// Shared types and constants of the reciprocal frequency meter.
// No dependencies.
package rfm_pkg;

   localparam int unsigned DATA_W            = 32;
   localparam int unsigned CAPTURE_FIELD_W   = 16;
   localparam int unsigned COUNTER_WIDTH_DEF = 16;
   localparam int unsigned OVERFLOW_WIDTH_DEF = 16;
   localparam int unsigned DIV_STEP_W        = $clog2(DATA_W);

   localparam logic [DATA_W-1:0] TIMER_CLOCK_RESET = 32'd84000000;

   // Capture counter saturates once a full period can be measured.
   localparam logic [1:0] CAPTURES_ONE  = 2'h1;
   localparam logic [1:0] CAPTURES_FULL = 2'h2;

   // Event codes on the request channel.
   localparam logic OP_OVERFLOW = 1'b0;
   localparam logic OP_CAPTURE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } rfm_state_type;

   typedef struct packed {
      logic start;
   } rfm_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rfm_div_stat_type;

endpackage

// ===== rtl/core/rfm_req_if.sv =====
// Request channel: capture and overflow events.
// Depends on rfm_pkg.
interface rfm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic [rfm_pkg::CAPTURE_FIELD_W-1:0] captured_count;

   modport source (output valid, output operation, output captured_count, input ready);
   modport sink   (input valid, input operation, input captured_count, output ready);
endinterface

// ===== rtl/core/rfm_rsp_if.sv =====
// Response channel: period and frequency per capture.
// Depends on rfm_pkg.
interface rfm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rfm_pkg::DATA_W-1:0] period_ticks;
   logic [rfm_pkg::DATA_W-1:0] frequency_hz;
   logic                       frequency_valid;

   modport source (output valid, output period_ticks, output frequency_hz,
                   output frequency_valid, input ready);
   modport sink   (input valid, input period_ticks, input frequency_hz,
                   input frequency_valid, output ready);
endinterface

// ===== rtl/core/rfm_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rfm_pkg.
module rfm_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  rfm_pkg::rfm_div_ctl_type   ctl,
   input  logic [rfm_pkg::DATA_W-1:0] dividend,
   input  logic [rfm_pkg::DATA_W-1:0] divisor,
   output rfm_pkg::rfm_div_stat_type  stat,
   output logic [rfm_pkg::DATA_W-1:0] quotient
);

   localparam int unsigned W = rfm_pkg::DATA_W;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [rfm_pkg::DIV_STEP_W-1:0]    step_ff, step_in;
   logic [W:0]                        rem_ff, rem_in;
   logic [W-1:0]                      quo_ff, quo_in;
   logic [W-1:0]                      dvs_ff, dvs_in;
   logic [W:0]                        shifted;
   logic [W:0]                        trial;

   always_comb begin
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = rfm_pkg::DIV_STEP_W'(W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ===== rtl/core/reciprocal_frequency_meter_unit.sv =====
// Reciprocal frequency meter: one response transaction per capture event.
// A capture with a valid period passes from accept through the 32 divider steps
// and done to emit; other captures pass from accept straight to emit.
// Overflow events produce no response. One event at a time; the radix-2 divider
// and the response sink set the rate. Synchronous active-high reset clears all
// counters, holds timer_clock_hz at 84 MHz and leaves the held frequency at 0.
// Depends on rfm_pkg, rfm_req_if, rfm_rsp_if, rfm_divider and the assert header.
`include "reciprocal_frequency_meter_unit_assert.svh"

module reciprocal_frequency_meter_unit #(
   parameter int unsigned COUNTER_WIDTH  = rfm_pkg::COUNTER_WIDTH_DEF,
   parameter int unsigned OVERFLOW_WIDTH = rfm_pkg::OVERFLOW_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   rfm_req_if.sink                    req_bus,
   rfm_rsp_if.source                  rsp_bus,
   input  logic                       csr_write_enable,
   input  logic [rfm_pkg::DATA_W-1:0] csr_write_data
);

   localparam int unsigned W = rfm_pkg::DATA_W;
   // Captured bits that survive the counter-width mask.
   localparam int unsigned CAP_W = (COUNTER_WIDTH < rfm_pkg::CAPTURE_FIELD_W) ?
                                   COUNTER_WIDTH : rfm_pkg::CAPTURE_FIELD_W;
   // Span width: room for overflows << COUNTER_WIDTH, at least 33 bits so the
   // saturation check always has bits above bit 31.
   localparam int unsigned RAW_W  = OVERFLOW_WIDTH + COUNTER_WIDTH;
   localparam int unsigned SPAN_W = ((RAW_W > W) ? RAW_W : W) + 1;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   rfm_pkg::rfm_state_type    state_ff, state_in;
   logic [W-1:0]              timer_clock_ff;
   logic [CAP_W-1:0]          last_capture_ff, last_capture_in;
   logic [OVERFLOW_WIDTH-1:0] overflow_ff, overflow_in;
   logic [1:0]                captures_ff, captures_in;
   logic [W-1:0]              held_freq_ff, held_freq_in;
   logic [W-1:0]              period_ff, period_in;
   logic                      valid_ff, valid_in;

   // Response holding register: frees the core while the sink stalls.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]              rsp_period_ff, rsp_period_in;
   logic [W-1:0]              rsp_freq_ff, rsp_freq_in;
   logic                      rsp_fvalid_ff, rsp_fvalid_in;

   // ---------------------------------------------------------------------
   // Period arithmetic on the accepted capture
   // ---------------------------------------------------------------------
   logic [CAP_W-1:0]  cap_masked;
   logic [SPAN_W-1:0] span;
   logic [SPAN_W-1:0] last_wide;
   logic [SPAN_W-1:0] diff;
   logic              backward;
   logic              too_long;
   logic [W-1:0]      period_new;
   logic              valid_new;

   assign cap_masked = req_bus.captured_count[CAP_W-1:0];
   assign span       = (SPAN_W'(overflow_ff) << COUNTER_WIDTH) + SPAN_W'(cap_masked);
   assign last_wide  = SPAN_W'(last_capture_ff);
   assign backward   = span < last_wide;
   assign diff       = span - last_wide;
   assign too_long   = |diff[SPAN_W-1:W];

   always_comb begin
      if (backward) begin
         period_new = '0;
      end else if (too_long) begin
         period_new = '1;
      end else begin
         period_new = diff[W-1:0];
      end
   end

   // Valid once a second capture is seen (count already nonzero) and the period is nonzero.
   assign valid_new = (captures_ff != 2'h0) && (period_new != '0);

   // ---------------------------------------------------------------------
   // Divider: timer_clock_hz / period
   // ---------------------------------------------------------------------
   rfm_pkg::rfm_div_ctl_type  div_ctl;
   rfm_pkg::rfm_div_stat_type div_stat;
   logic [W-1:0]              div_quotient;

   rfm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (timer_clock_ff),
      .divisor  (period_new),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   logic req_fire;
   logic rsp_slot_free;

   assign req_bus.ready = (state_ff == rfm_pkg::ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in        = state_ff;
      last_capture_in = last_capture_ff;
      overflow_in     = overflow_ff;
      captures_in     = captures_ff;
      held_freq_in    = held_freq_ff;
      period_in       = period_ff;
      valid_in        = valid_ff;
      div_ctl.start   = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_period_in   = rsp_period_ff;
      rsp_freq_in     = rsp_freq_ff;
      rsp_fvalid_in   = rsp_fvalid_ff;

      unique case (state_ff)
         rfm_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.operation)
                  rfm_pkg::OP_OVERFLOW: begin
                     // Saturating overflow count; no response.
                     if (overflow_ff != '1) begin
                        overflow_in = overflow_ff + 1'b1;
                     end
                  end
                  rfm_pkg::OP_CAPTURE: begin
                     last_capture_in = cap_masked;
                     overflow_in     = '0;
                     if (captures_ff != rfm_pkg::CAPTURES_FULL) begin
                        captures_in = captures_ff + rfm_pkg::CAPTURES_ONE;
                     end
                     period_in = period_new;
                     valid_in  = valid_new;
                     if (valid_new) begin
                        div_ctl.start = 1'b1;
                        state_in      = rfm_pkg::ST_DIVIDE;
                     end else begin
                        state_in = rfm_pkg::ST_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         rfm_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               held_freq_in = div_quotient;
               state_in     = rfm_pkg::ST_EMIT;
            end
         end
         rfm_pkg::ST_EMIT: begin
            // held_freq_ff already carries the new quotient on a valid period.
            if (rsp_slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_period_in = period_ff;
               rsp_freq_in   = held_freq_ff;
               rsp_fvalid_in = valid_ff;
               state_in      = rfm_pkg::ST_IDLE;
            end
         end
         default: state_in = rfm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= rfm_pkg::ST_IDLE;
         timer_clock_ff  <= rfm_pkg::TIMER_CLOCK_RESET;
         last_capture_ff <= '0;
         overflow_ff     <= '0;
         captures_ff     <= '0;
         held_freq_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         if (csr_write_enable) begin
            timer_clock_ff <= csr_write_data;
         end
         last_capture_ff <= last_capture_in;
         overflow_ff     <= overflow_in;
         captures_ff     <= captures_in;
         held_freq_ff    <= held_freq_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      period_ff     <= period_in;
      valid_ff      <= valid_in;
      rsp_period_ff <= rsp_period_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_fvalid_ff <= rsp_fvalid_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.period_ticks    = rsp_period_ff;
   assign rsp_bus.frequency_hz    = rsp_freq_ff;
   assign rsp_bus.frequency_valid = rsp_fvalid_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // The divider is never running while new events are taken.
   `RFM_ASSERT_NOW(a_idle_div_quiet, clock, reset, req_bus.ready, !div_stat.busy)
   // Divider completion only lands in the divide state.
   `RFM_ASSERT_NOW(a_done_in_divide, clock, reset, div_stat.done,
                   state_ff == rfm_pkg::ST_DIVIDE)
   // A capture transaction always leaves idle.
   `RFM_ASSERT_NEXT(a_capture_busy, clock, reset,
                    req_fire && (req_bus.operation == rfm_pkg::OP_CAPTURE),
                    state_ff != rfm_pkg::ST_IDLE)
   // A valid frequency is never reported against a zero period.
   `RFM_ASSERT_NOW(a_valid_period, clock, reset,
                   rsp_bus.valid && rsp_bus.frequency_valid, rsp_bus.period_ticks != '0)

endmodule
